// File: rtl/dbas_pkg.sv
// ----------------------------------------------------------------------------
// Double beep alarm sequencer package
// Shared types, codes and constants of the alarm beeper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbas_pkg;

  localparam int OP_W     = 2;
  localparam int DUR_W    = 16;
  localparam int MS_W     = 16;
  localparam int FREQ_W   = 15;
  localparam int PHASE_W  = 3;
  localparam int ALARM_W  = 26;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BEEP1  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PAUSE1 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BEEP2  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAUSE2 = 3'd4;

  localparam logic [CFG_A_W-1:0] REG_BEEP_MS        = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SHORT_PAUSE_MS = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_LONG_PAUSE_MS  = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_TONE_HZ        = 2'd3;

  localparam logic [MS_W-1:0]   RST_BEEP_MS        = 16'd200;
  localparam logic [MS_W-1:0]   RST_SHORT_PAUSE_MS = 16'd200;
  localparam logic [MS_W-1:0]   RST_LONG_PAUSE_MS  = 16'd1000;
  localparam logic [FREQ_W-1:0] RST_TONE_HZ        = 15'd880;

  localparam logic [ALARM_W-1:0] MS_PER_S  = 26'd1000;
  localparam logic [ALARM_W-1:0] ALARM_MAX = {ALARM_W{1'b1}};
  localparam logic [MS_W-1:0]    PHASE_MAX = {MS_W{1'b1}};

  typedef struct packed {
    logic [MS_W-1:0]   beep_ms;
    logic [MS_W-1:0]   short_pause_ms;
    logic [MS_W-1:0]   long_pause_ms;
    logic [FREQ_W-1:0] tone_hz;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DUR_W-1:0] duration_s;
  } item_t;

  typedef struct packed {
    logic               tone_on;
    logic [FREQ_W-1:0]  tone_freq;
    logic               alarm_active;
    logic [PHASE_W-1:0] pattern_phase;
  } status_t;

endpackage

// File: rtl/dbas_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the beep, pause and tone settings written through the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbas_cfg_regs import dbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beep_ms        <= RST_BEEP_MS;
      cfg_r.short_pause_ms <= RST_SHORT_PAUSE_MS;
      cfg_r.long_pause_ms  <= RST_LONG_PAUSE_MS;
      cfg_r.tone_hz        <= RST_TONE_HZ;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BEEP_MS:        cfg_r.beep_ms        <= cfg_wdata;
        REG_SHORT_PAUSE_MS: cfg_r.short_pause_ms <= cfg_wdata;
        REG_LONG_PAUSE_MS:  cfg_r.long_pause_ms  <= cfg_wdata;
        REG_TONE_HZ:        cfg_r.tone_hz        <= cfg_wdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/dbas_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one accepted transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbas_in_stage import dbas_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_op,
  input  logic [DUR_W-1:0] in_duration_s,
  input  logic             take,
  output logic             s1_valid,
  output item_t            s1_item
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op         <= in_op;
      item_r.duration_s <= in_duration_s;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: rtl/dbas_core.sv
// ----------------------------------------------------------------------------
// Sequencer core
// Alarm and phase timers, the beep pattern state and the status it reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbas_core import dbas_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   s1_item,
  input  cfg_t    cfg,
  output status_t status_nxt
);

  logic               active_r,  active_nxt;
  logic [PHASE_W-1:0] phase_r,   phase_nxt;
  logic [ALARM_W-1:0] alarm_r,   alarm_nxt;
  logic [ALARM_W-1:0] limit_r,   limit_nxt;
  logic [MS_W-1:0]    ph_el_r,   ph_el_nxt;
  logic [ALARM_W-1:0] alarm_inc;
  logic [MS_W-1:0]    ph_el_inc;
  logic               tone;

  assign alarm_inc = (alarm_r < ALARM_MAX) ? alarm_r + 1'b1 : alarm_r;
  assign ph_el_inc = (ph_el_r < PHASE_MAX) ? ph_el_r + 1'b1 : ph_el_r;

  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    alarm_nxt  = alarm_r;
    limit_nxt  = limit_r;
    ph_el_nxt  = ph_el_r;
    case (s1_item.op)
      OP_TICK: begin
        if (active_r) begin
          alarm_nxt = alarm_inc;
          ph_el_nxt = ph_el_inc;
          if (alarm_inc >= limit_r) begin
            active_nxt = 1'b0;
            phase_nxt  = PH_IDLE;
          end else begin
            case (phase_r)
              PH_BEEP1: begin
                if (ph_el_inc >= cfg.beep_ms) begin
                  phase_nxt = PH_PAUSE1;
                  ph_el_nxt = '0;
                end
              end
              PH_PAUSE1: begin
                if (ph_el_inc >= cfg.short_pause_ms) begin
                  phase_nxt = PH_BEEP2;
                  ph_el_nxt = '0;
                end
              end
              PH_BEEP2: begin
                if (ph_el_inc >= cfg.beep_ms) begin
                  phase_nxt = PH_PAUSE2;
                  ph_el_nxt = '0;
                end
              end
              PH_PAUSE2: begin
                if (ph_el_inc >= cfg.long_pause_ms) begin
                  phase_nxt = PH_BEEP1;
                  ph_el_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_TRIGGER: begin
        if (!active_r) begin
          active_nxt = 1'b1;
          phase_nxt  = PH_BEEP1;
          alarm_nxt  = '0;
          ph_el_nxt  = '0;
          limit_nxt  = ALARM_W'(ALARM_W'(s1_item.duration_s) * MS_PER_S);
        end
      end
      OP_STOP: begin
        active_nxt = 1'b0;
        phase_nxt  = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= PH_IDLE;
      alarm_r  <= '0;
      limit_r  <= '0;
      ph_el_r  <= '0;
    end else if (take) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      alarm_r  <= alarm_nxt;
      limit_r  <= limit_nxt;
      ph_el_r  <= ph_el_nxt;
    end
  end

  assign tone = active_nxt && (phase_nxt == PH_BEEP1 || phase_nxt == PH_BEEP2);

  assign status_nxt.tone_on       = tone;
  assign status_nxt.tone_freq     = tone ? cfg.tone_hz : '0;
  assign status_nxt.alarm_active  = active_nxt;
  assign status_nxt.pattern_phase = phase_nxt;

  a_phase_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) == active_r)
    else $error("phase and active flag disagree");

  a_trigger_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_item.op == OP_TRIGGER && !active_r)
    |=> (active_r && phase_r == PH_BEEP1 && alarm_r == '0))
    else $error("trigger from idle did not start beep one");

  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_item.op == OP_STOP) |=> (!active_r && phase_r == PH_IDLE))
    else $error("stop did not force idle");

  a_timer_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (alarm_r <= limit_r))
    else $error("alarm timer ran past its limit while active");

endmodule

// File: rtl/dbas_out_stage.sv
// ----------------------------------------------------------------------------
// Result stage
// Result register of the status channel and the take signal for the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbas_out_stage import dbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  status_t            status_nxt,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_tone_on,
  output logic [FREQ_W-1:0]  out_tone_freq,
  output logic               out_alarm_active,
  output logic [PHASE_W-1:0] out_pattern_phase
);

  logic    valid_r;
  status_t res_r;

  assign take = s1_valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= status_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_tone_on       = res_r.tone_on;
  assign out_tone_freq     = res_r.tone_freq;
  assign out_alarm_active  = res_r.alarm_active;
  assign out_pattern_phase = res_r.pattern_phase;

endmodule

// File: rtl/double_beep_alarm_sequencer.sv
// ----------------------------------------------------------------------------
// Double beep alarm sequencer
// Alarm beeper driven by millisecond ticks, trigger and stop transactions.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    op, duration_s
//   out      output     out_valid/out_stall  tone_on, tone_freq, alarm_active,
//                                            pattern_phase
//   cfg      input      cfg_we               cfg_addr, cfg_wdata
//
// An accepted transaction is held in the input register and then passes
// through the sequencer core into the result register.
// One transaction is accepted per cycle while the result side keeps taking.
// Reset is synchronous and returns the settings to their defaults and the
// sequencer to idle; no clearing pass follows.
// A stalled result holds the core, and the input stall follows at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_beep_alarm_sequencer import dbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [DUR_W-1:0]   in_duration_s,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_tone_on,
  output logic [FREQ_W-1:0]  out_tone_freq,
  output logic               out_alarm_active,
  output logic [PHASE_W-1:0] out_pattern_phase,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   s1_item;
  status_t status_nxt;
  logic    s1_valid;
  logic    take;

  dbas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbas_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_duration_s (in_duration_s),
    .take          (take),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item)
  );

  dbas_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .s1_item    (s1_item),
    .cfg        (cfg),
    .status_nxt (status_nxt)
  );

  dbas_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid),
    .status_nxt        (status_nxt),
    .take              (take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tone_on       (out_tone_on),
    .out_tone_freq     (out_tone_freq),
    .out_alarm_active  (out_alarm_active),
    .out_pattern_phase (out_pattern_phase)
  );

endmodule

// File: tb/sv/double_beep_alarm_sequencer_test.sv
// ----------------------------------------------------------------------------
// Double beep alarm sequencer testbench
// Drives tick, trigger and stop transactions into the alarm beeper, with
// random gaps and result stalls. An alarm status predictor follows every
// accepted transaction and checks all fields of each result. The settings
// are rewritten between phases, including zero and full-scale values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_beep_alarm_sequencer_test;
  import dbas_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              RANDOM_ITEMS   = 1300;
  localparam int              PHASE_ITEMS    = 40;

  class alarm_scoreboard;
    cfg_t               regs;
    logic               running;
    logic [PHASE_W-1:0] phase;
    logic [ALARM_W-1:0] alarm_ms;
    logic [DUR_W-1:0]   limit_s;
    logic [MS_W-1:0]    phase_ms;
    status_t            pending_status[$];
    int                 failures;

    function new();
      regs.beep_ms        = RST_BEEP_MS;
      regs.short_pause_ms = RST_SHORT_PAUSE_MS;
      regs.long_pause_ms  = RST_LONG_PAUSE_MS;
      regs.tone_hz        = RST_TONE_HZ;
      running  = 1'b0;
      phase    = PH_IDLE;
      alarm_ms = '0;
      limit_s  = '0;
      phase_ms = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
      case (idx)
        REG_BEEP_MS:        regs.beep_ms        = val;
        REG_SHORT_PAUSE_MS: regs.short_pause_ms = val;
        REG_LONG_PAUSE_MS:  regs.long_pause_ms  = val;
        REG_TONE_HZ:        regs.tone_hz        = val[FREQ_W-1:0];
        default: ;
      endcase
    endfunction

    function void enter(logic [PHASE_W-1:0] next);
      phase    = next;
      phase_ms = '0;
    endfunction

    function void count_ms();
      if (!running) return;
      if (alarm_ms != ALARM_MAX) alarm_ms = alarm_ms + 1'b1;
      if (phase_ms != PHASE_MAX) phase_ms = phase_ms + 1'b1;
      if (32'(alarm_ms) >= 32'(limit_s) * 32'(MS_PER_S)) begin
        running = 1'b0;
        phase   = PH_IDLE;
        return;
      end
      case (phase)
        PH_BEEP1:  if (phase_ms >= regs.beep_ms) enter(PH_PAUSE1);
        PH_PAUSE1: if (phase_ms >= regs.short_pause_ms) enter(PH_BEEP2);
        PH_BEEP2:  if (phase_ms >= regs.beep_ms) enter(PH_PAUSE2);
        PH_PAUSE2: if (phase_ms >= regs.long_pause_ms) enter(PH_BEEP1);
        default: ;
      endcase
    endfunction

    function void take_command(logic [OP_W-1:0] op, logic [DUR_W-1:0] dur);
      status_t s;
      logic    on;
      case (op)
        OP_TICK: count_ms();
        OP_TRIGGER: begin
          if (!running) begin
            running  = 1'b1;
            alarm_ms = '0;
            limit_s  = dur;
            enter(PH_BEEP1);
          end
        end
        OP_STOP: begin
          running = 1'b0;
          phase   = PH_IDLE;
        end
        default: ;
      endcase
      on = running && (phase == PH_BEEP1 || phase == PH_BEEP2);
      s.tone_on       = on;
      s.tone_freq     = on ? regs.tone_hz : '0;
      s.alarm_active  = running;
      s.pattern_phase = phase;
      pending_status.push_back(s);
    endfunction

    function void check_status(logic tone_on, logic [FREQ_W-1:0] freq, logic active,
                               logic [PHASE_W-1:0] ph);
      status_t got;
      status_t want;
      got = {tone_on, freq, active, ph};
      if (pending_status.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: tone_on=%0d freq=%0d active=%0d phase=%0d",
                   tone_on, freq, active, ph);
        return;
      end
      want = pending_status.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $write("Status mismatch: expected tone_on=%0d freq=%0d active=%0d phase=%0d,",
                 want.tone_on, want.tone_freq, want.alarm_active, want.pattern_phase);
          $display(" got tone_on=%0d freq=%0d active=%0d phase=%0d",
                   tone_on, freq, active, ph);
        end
      end
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_op = OP_TICK;
  logic [DUR_W-1:0]   in_duration_s = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_tone_on;
  logic [FREQ_W-1:0]  out_tone_freq;
  logic               out_alarm_active;
  logic [PHASE_W-1:0] out_pattern_phase;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = REG_BEEP_MS;
  logic [CFG_D_W-1:0] cfg_wdata = '0;

  alarm_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  in_quiet = 1'b0;
  int  random_items = 0;

  double_beep_alarm_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_duration_s    (in_duration_s),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_on      (out_tone_on),
    .out_tone_freq    (out_tone_freq),
    .out_alarm_active (out_alarm_active),
    .out_pattern_phase(out_pattern_phase),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_command(in_op, in_duration_s);
      if (out_valid && !out_stall)
        sb.check_status(out_tone_on, out_tone_freq, out_alarm_active, out_pattern_phase);
      idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 :
                     idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  initial begin
    int n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 2) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        n = gap_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Sends one transaction and waits until it is accepted.
  task automatic issue(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur);
    int  n;
    n = in_quiet ? 0 : gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_duration_s <= dur;
    do @(posedge clk); while (in_stall);
    random_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [MS_W-1:0] beep, input logic [MS_W-1:0] gap1,
                                input logic [MS_W-1:0] gap2, input logic [FREQ_W-1:0] hz);
    logic [CFG_A_W-1:0] addrs [4];
    logic [CFG_D_W-1:0] vals [4];
    addrs = '{REG_BEEP_MS, REG_SHORT_PAUSE_MS, REG_LONG_PAUSE_MS, REG_TONE_HZ};
    vals  = '{beep, gap1, gap2, {1'($urandom), hz}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      sb.write_reg(addrs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [MS_W-1:0] pick_ms();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return PHASE_MAX;
    if (r < 3) return MS_W'($urandom);
    return MS_W'($urandom_range(0, 6));
  endfunction

  function automatic logic [FREQ_W-1:0] pick_hz();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return FREQ_W'(20000);
    return FREQ_W'($urandom);
  endfunction

  task automatic run_alarm();
    int                n;
    int                r;
    logic [DUR_W-1:0]  dur;
    r = $urandom_range(0, 9);
    if (r < 4) dur = '0;
    else if (r < 7) dur = DUR_W'($urandom);
    else dur = DUR_W'($urandom_range(1, 3));
    issue(OP_TRIGGER, dur);
    n = $urandom_range(0, 40);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 88) issue(OP_TICK, DUR_W'($urandom));
      else if (r < 93) issue(OP_TRIGGER, DUR_W'($urandom));
      else if (r < 97) issue(OP_UNUSED, DUR_W'($urandom));
      else begin
        drain();
        issue(OP_TICK, DUR_W'($urandom));
      end
    end
    if ($urandom_range(0, 2) != 0) issue(OP_STOP, DUR_W'($urandom));
  endtask

  initial begin
    int phase_end;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle behavior, unused code, ignored retrigger and an
    // alarm of zero seconds that ends on its first tick.
    issue(OP_TICK, 16'hFFFF);
    issue(OP_STOP, 16'h0000);
    issue(OP_UNUSED, 16'hAAAA);
    issue(OP_TRIGGER, 16'h0000);
    issue(OP_TRIGGER, 16'hFFFF);
    issue(OP_UNUSED, 16'h5555);
    issue(OP_TICK, 16'h0000);
    drain();

    // Zero-length beep and zero tone: every pattern step is walked through.
    write_settings(16'd0, 16'd1, 16'd2, 15'd0);
    issue(OP_TRIGGER, 16'hFFFF);
    repeat (6) issue(OP_TICK, 16'h0000);
    issue(OP_STOP, 16'hFFFF);
    issue(OP_TRIGGER, 16'h5555);
    issue(OP_UNUSED, 16'h0000);
    issue(OP_STOP, 16'h0000);
    issue(OP_TICK, 16'h0000);
    drain();

    random_items = 0;
    k = 0;
    while (random_items < RANDOM_ITEMS) begin
      in_quiet = (k % 3 == 1);
      case (k)
        0: write_settings(PHASE_MAX, PHASE_MAX, PHASE_MAX, {FREQ_W{1'b1}});
        1: write_settings('0, '0, '0, FREQ_W'(20000));
        2: write_settings(16'd1, 16'd1, 16'd1, 15'd1);
        default: write_settings(pick_ms(), pick_ms(), pick_ms(), pick_hz());
      endcase
      if (k == 3) begin
        // A one-second alarm runs through to its natural end.
        issue(OP_STOP, DUR_W'($urandom));
        issue(OP_TRIGGER, 16'd1);
        repeat (int'(MS_PER_S) + 3) issue(OP_TICK, DUR_W'($urandom));
      end
      phase_end = random_items + PHASE_ITEMS;
      while (random_items < phase_end && random_items < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) < 8) run_alarm();
        else issue(OP_W'($urandom), DUR_W'($urandom));
      end
      drain();
      k++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/dbas_pkg.sv
rtl/dbas_cfg_regs.sv
rtl/dbas_in_stage.sv
rtl/dbas_core.sv
rtl/dbas_out_stage.sv
rtl/double_beep_alarm_sequencer.sv
tb/sv/double_beep_alarm_sequencer_test.sv
